@@ hw/rtl/fjot_pkg.sv @@
// ----------------------------------------------------------------------------
// fjot_pkg
// Shared types and codes for the flat object tokenizer: transfer payloads,
// parser phase codes, result kinds and error codes.
// ----------------------------------------------------------------------------
package fjot_pkg;

    // input transfer payload
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_msg;
    } t_in;

    // result transfer payload
    typedef struct packed {
        logic [2:0]  out_kind;
        logic [7:0]  out_byte;
        logic [2:0]  error_code;
        logic [15:0] byte_pos;
        logic [15:0] pairs_seen;
    } t_out;

    // parser control state (position counter travels separately)
    typedef struct packed {
        logic [3:0]  phase;
        logic        esc;
        logic [15:0] pairs;
        logic [2:0]  err;
    } t_ctl;

    // parser phases
    localparam logic [3:0] PH_INIT = 4'd0;
    localparam logic [3:0] PH_OTAG = 4'd1;
    localparam logic [3:0] PH_ITAG = 4'd2;
    localparam logic [3:0] PH_ETAG = 4'd3;
    localparam logic [3:0] PH_OVAL = 4'd4;
    localparam logic [3:0] PH_IVAL = 4'd5;
    localparam logic [3:0] PH_EVAL = 4'd6;
    localparam logic [3:0] PH_DONE = 4'd7;
    localparam logic [3:0] PH_ERR  = 4'd8;

    // result kinds
    localparam logic [2:0] K_SKIP = 3'd0;
    localparam logic [2:0] K_TAG  = 3'd1;
    localparam logic [2:0] K_VAL  = 3'd2;
    localparam logic [2:0] K_TEND = 3'd3;
    localparam logic [2:0] K_PEND = 3'd4;
    localparam logic [2:0] K_OEND = 3'd5;
    localparam logic [2:0] K_ERR  = 3'd6;

    // error codes
    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_BRACE = 3'd1;
    localparam logic [2:0] E_QUOTE = 3'd2;
    localparam logic [2:0] E_COLON = 3'd3;
    localparam logic [2:0] E_SEP   = 3'd4;

    // punctuation
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [15:0] PAIRS_MAX = 16'hFFFF;

endpackage

@@ hw/rtl/fjot_step.sv @@
// ----------------------------------------------------------------------------
// fjot_step
// Per-byte parser logic: from the current state and one input byte, forms
// the result and the next state.
// ----------------------------------------------------------------------------
module fjot_step #(
    parameter int POSITION_BITS = 16
) (
    input  fjot_pkg::t_in             i_data,
    input  fjot_pkg::t_ctl            i_state,
    input  logic [POSITION_BITS-1:0]  i_pos,
    output fjot_pkg::t_ctl            o_state,
    output logic [POSITION_BITS-1:0]  o_pos,
    output fjot_pkg::t_out            o_result
);

    fjot_pkg::t_ctl             cur;
    fjot_pkg::t_ctl             nxt;
    logic [POSITION_BITS-1:0]   pos;
    logic [2:0]                 kind;
    logic [7:0]                 obyte;
    logic [7:0]                 c;
    logic                       blank;
    logic [15:0]                pos_rep;

    // start of message clears state before this byte
    always_comb begin
        if (i_data.start_msg) begin
            cur.phase = fjot_pkg::PH_INIT;
            cur.esc   = 1'b0;
            cur.pairs = '0;
            cur.err   = fjot_pkg::E_NONE;
            pos       = '0;
        end else begin
            cur = i_state;
            pos = i_pos;
        end
    end

    assign c     = i_data.in_byte;
    assign blank = (c == fjot_pkg::CH_SPACE) ||
                   ((c >= fjot_pkg::CH_TAB) && (c <= fjot_pkg::CH_CR));

    // phase transitions and byte classification
    always_comb begin
        nxt   = cur;
        kind  = fjot_pkg::K_SKIP;
        obyte = 8'd0;
        case (cur.phase)
            fjot_pkg::PH_INIT: begin
                if (!blank) begin
                    if (c == fjot_pkg::CH_LBRACE) begin
                        nxt.phase = fjot_pkg::PH_OTAG;
                    end else begin
                        nxt.phase = fjot_pkg::PH_ERR;
                        nxt.err   = fjot_pkg::E_BRACE;
                        kind      = fjot_pkg::K_ERR;
                    end
                end
            end
            fjot_pkg::PH_OTAG, fjot_pkg::PH_OVAL: begin
                if (!blank) begin
                    if (c == fjot_pkg::CH_QUOTE) begin
                        nxt.phase = (cur.phase == fjot_pkg::PH_OTAG) ?
                                    fjot_pkg::PH_ITAG : fjot_pkg::PH_IVAL;
                        nxt.esc   = 1'b0;
                    end else begin
                        nxt.phase = fjot_pkg::PH_ERR;
                        nxt.err   = fjot_pkg::E_QUOTE;
                        kind      = fjot_pkg::K_ERR;
                    end
                end
            end
            fjot_pkg::PH_ITAG, fjot_pkg::PH_IVAL: begin
                if (cur.esc) begin
                    nxt.esc = 1'b0;
                    kind    = (cur.phase == fjot_pkg::PH_ITAG) ?
                              fjot_pkg::K_TAG : fjot_pkg::K_VAL;
                    obyte   = c;
                end else if (c == fjot_pkg::CH_BSLASH) begin
                    nxt.esc = 1'b1;
                end else if (c == fjot_pkg::CH_QUOTE) begin
                    if (cur.phase == fjot_pkg::PH_ITAG) begin
                        nxt.phase = fjot_pkg::PH_ETAG;
                        kind      = fjot_pkg::K_TEND;
                    end else begin
                        nxt.phase = fjot_pkg::PH_EVAL;
                        kind      = fjot_pkg::K_PEND;
                        if (cur.pairs != fjot_pkg::PAIRS_MAX) begin
                            nxt.pairs = cur.pairs + 16'd1;
                        end
                    end
                end else begin
                    kind  = (cur.phase == fjot_pkg::PH_ITAG) ?
                            fjot_pkg::K_TAG : fjot_pkg::K_VAL;
                    obyte = c;
                end
            end
            fjot_pkg::PH_ETAG: begin
                if (!blank) begin
                    if (c == fjot_pkg::CH_COLON) begin
                        nxt.phase = fjot_pkg::PH_OVAL;
                    end else begin
                        nxt.phase = fjot_pkg::PH_ERR;
                        nxt.err   = fjot_pkg::E_COLON;
                        kind      = fjot_pkg::K_ERR;
                    end
                end
            end
            fjot_pkg::PH_EVAL: begin
                if (!blank) begin
                    if (c == fjot_pkg::CH_COMMA) begin
                        nxt.phase = fjot_pkg::PH_OTAG;
                    end else if (c == fjot_pkg::CH_RBRACE) begin
                        nxt.phase = fjot_pkg::PH_DONE;
                        kind      = fjot_pkg::K_OEND;
                    end else begin
                        nxt.phase = fjot_pkg::PH_ERR;
                        nxt.err   = fjot_pkg::E_SEP;
                        kind      = fjot_pkg::K_ERR;
                    end
                end
            end
            fjot_pkg::PH_ERR: begin
                kind = fjot_pkg::K_ERR;
            end
            default: begin
            end
        endcase
    end

    // saturating position counter
    assign o_pos = (&pos) ? pos : pos + POSITION_BITS'(1);

    // reported position clamps to 16 bits
    generate
        if (POSITION_BITS > 16) begin : g_pos_wide
            assign pos_rep = (|pos[POSITION_BITS-1:16]) ? 16'hFFFF : pos[15:0];
        end else begin : g_pos_narrow
            assign pos_rep = 16'(pos);
        end
    endgenerate

    assign o_state             = nxt;
    assign o_result.out_kind   = kind;
    assign o_result.out_byte   = obyte;
    assign o_result.error_code = nxt.err;
    assign o_result.byte_pos   = pos_rep;
    assign o_result.pairs_seen = nxt.pairs;

endmodule

@@ hw/rtl/flat_json_object_tokenizer_unit.sv @@
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_unit
// Streams a flat object of quoted string pairs one byte per transfer and
// returns one classification result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) carries one raw byte
//   per transfer; start_msg set marks the first byte of a new message and
//   clears parser state, counters and any held error first.
//   Output channel (o_out_valid / o_out_data / i_out_stall) returns exactly
//   one result per input byte, in order: kind, copied byte, held error code,
//   byte position and completed pair count.
//   Path: a byte accepted from the input channel is held in the input
//   register; the step logic forms its result, which is then registered
//   in the output register that drives o_out.
//   Throughput: one byte per cycle unless the output stalls; the parser
//   state is a single register set updated once per byte by the step logic.
//   Reset (i_rst_n low, synchronous) empties both registers and puts the
//   parser back to waiting for an opening brace.
//   When the receiver stalls, the result holds; the input register keeps
//   taking one more byte, then o_in_stall rises until the output drains.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  fjot_pkg::t_in     i_in_data,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output fjot_pkg::t_out    o_out_data,
    input  logic              i_out_stall
);

    logic                       r_in_valid;
    fjot_pkg::t_in              r_in_data;
    logic                       r_out_valid;
    fjot_pkg::t_out             r_out_data;
    fjot_pkg::t_ctl             r_state;
    logic [POSITION_BITS-1:0]   r_pos;

    fjot_pkg::t_ctl             n_state;
    logic [POSITION_BITS-1:0]   n_pos;
    fjot_pkg::t_out             n_result;
    logic                       advance;
    logic                       in_take;

    // handshake: output register frees when empty or drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // per-byte parser logic
    fjot_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_data   (r_in_data),
        .i_state  (r_state),
        .i_pos    (r_pos),
        .o_state  (n_state),
        .o_pos    (n_pos),
        .o_result (n_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_data <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_result;
        end
    end

    // parser state, updated once per byte moved to the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= fjot_pkg::PH_INIT;
            r_state.esc   <= 1'b0;
            r_state.pairs <= '0;
            r_state.err   <= fjot_pkg::E_NONE;
            r_pos         <= '0;
        end else if (advance && r_in_valid) begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // an error result always carries its code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.out_kind == fjot_pkg::K_ERR)
        |-> (o_out_data.error_code != fjot_pkg::E_NONE))
        else $error("error result without error code");

    // only tag and value bytes copy data
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.out_kind != fjot_pkg::K_TAG) &&
        (o_out_data.out_kind != fjot_pkg::K_VAL)
        |-> (o_out_data.out_byte == 8'd0))
        else $error("copied byte on non-data result");

    // a held error means the parser sits in the error phase
    a_err_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.err != fjot_pkg::E_NONE) |-> (r_state.phase == fjot_pkg::PH_ERR))
        else $error("held error outside error phase");

    // stall toward the sender only while a byte is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with free registers");

    // a stalled output leaves the parser state untouched
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_state))
        else $error("parser state moved during output stall");

endmodule

@@ tb/flat_json_object_tokenizer_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer_unit_test
// Streams directed and random flat objects through the tokenizer, predicts
// every per-byte result with a behavioral parser and compares each result
// field by field, with random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer_unit_test;

    localparam int RANDOM_BYTES  = 1250;
    localparam int IDLE_PCT      = 9;
    localparam int QUIET_FROM    = 800;
    localparam int QUIET_TO      = 1400;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int STUCK_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 8;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_in_valid = 1'b0;
    fjot_pkg::t_in  i_in_data = '0;
    logic           o_in_stall;
    logic           o_out_valid;
    fjot_pkg::t_out o_out_data;
    logic           i_out_stall = 1'b0;

    // byte stream waiting to be offered and results still owed by the block
    fjot_pkg::t_in  pending_bytes[$];
    fjot_pkg::t_out owed_results[$];
    logic [7:0]     msg_buf[$];

    // parser state mirror
    logic [3:0]  parse_state = fjot_pkg::PH_INIT;
    logic        escape_armed = 1'b0;
    logic [15:0] position = '0;
    logic [15:0] pair_total = '0;
    logic [2:0]  latched_error = fjot_pkg::E_NONE;

    int fail_count = 0;
    int cycle_count = 0;
    int stuck_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int bytes_sent = 0;
    int results_checked = 0;
    int objects_closed = 0;
    int error_results = 0;
    int messages_sent = 0;
    int random_bytes = 0;

    flat_json_object_tokenizer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic bit is_blank(input logic [7:0] c);
        return c == fjot_pkg::CH_SPACE || (c >= fjot_pkg::CH_TAB && c <= fjot_pkg::CH_CR);
    endfunction

    function automatic logic [2:0] latch_error(input logic [2:0] code);
        latched_error = code;
        parse_state   = fjot_pkg::PH_ERR;
        return fjot_pkg::K_ERR;
    endfunction

    // one parser step: updates the mirrored state and returns the result
    function automatic fjot_pkg::t_out tokenize_byte(input fjot_pkg::t_in item);
        fjot_pkg::t_out r;
        logic [7:0]     c;
        c = item.in_byte;
        if (item.start_msg) begin
            parse_state   = fjot_pkg::PH_INIT;
            escape_armed  = 1'b0;
            position      = '0;
            pair_total    = '0;
            latched_error = fjot_pkg::E_NONE;
        end
        r          = '0;
        r.out_kind = fjot_pkg::K_SKIP;
        r.byte_pos = position;
        case (parse_state)
            fjot_pkg::PH_INIT: begin
                if (!is_blank(c)) begin
                    if (c == fjot_pkg::CH_LBRACE) parse_state = fjot_pkg::PH_OTAG;
                    else r.out_kind = latch_error(fjot_pkg::E_BRACE);
                end
            end
            fjot_pkg::PH_OTAG, fjot_pkg::PH_OVAL: begin
                if (!is_blank(c)) begin
                    if (c == fjot_pkg::CH_QUOTE) begin
                        parse_state  = (parse_state == fjot_pkg::PH_OTAG) ?
                                       fjot_pkg::PH_ITAG : fjot_pkg::PH_IVAL;
                        escape_armed = 1'b0;
                    end else begin
                        r.out_kind = latch_error(fjot_pkg::E_QUOTE);
                    end
                end
            end
            fjot_pkg::PH_ITAG, fjot_pkg::PH_IVAL: begin
                if (escape_armed ||
                    (c != fjot_pkg::CH_BSLASH && c != fjot_pkg::CH_QUOTE)) begin
                    escape_armed = 1'b0;
                    r.out_kind   = (parse_state == fjot_pkg::PH_ITAG) ?
                                   fjot_pkg::K_TAG : fjot_pkg::K_VAL;
                    r.out_byte   = c;
                end else if (c == fjot_pkg::CH_BSLASH) begin
                    escape_armed = 1'b1;
                end else if (parse_state == fjot_pkg::PH_ITAG) begin
                    parse_state = fjot_pkg::PH_ETAG;
                    r.out_kind  = fjot_pkg::K_TEND;
                end else begin
                    parse_state = fjot_pkg::PH_EVAL;
                    r.out_kind  = fjot_pkg::K_PEND;
                    if (pair_total != fjot_pkg::PAIRS_MAX) pair_total = pair_total + 1'b1;
                end
            end
            fjot_pkg::PH_ETAG: begin
                if (!is_blank(c)) begin
                    if (c == fjot_pkg::CH_COLON) parse_state = fjot_pkg::PH_OVAL;
                    else r.out_kind = latch_error(fjot_pkg::E_COLON);
                end
            end
            fjot_pkg::PH_EVAL: begin
                if (!is_blank(c)) begin
                    if (c == fjot_pkg::CH_COMMA) begin
                        parse_state = fjot_pkg::PH_OTAG;
                    end else if (c == fjot_pkg::CH_RBRACE) begin
                        parse_state = fjot_pkg::PH_DONE;
                        r.out_kind  = fjot_pkg::K_OEND;
                    end else begin
                        r.out_kind = latch_error(fjot_pkg::E_SEP);
                    end
                end
            end
            fjot_pkg::PH_ERR: r.out_kind = fjot_pkg::K_ERR;
            default: ;
        endcase
        if (position != 16'hFFFF) position = position + 1'b1;
        r.error_code = latched_error;
        r.pairs_seen = pair_total;
        return r;
    endfunction

    function automatic bit idle_now();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                owed_results.push_back(tokenize_byte(i_in_data));
                bytes_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_bytes.size() != 0 && !idle_now()) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_bytes.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        fjot_pkg::t_out want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_checked++;
                if (owed_results.size() == 0) begin
                    $error("out_kind: expected no transfer, got %0d", o_out_data.out_kind);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (want.out_kind == fjot_pkg::K_OEND) objects_closed++;
                    if (want.out_kind == fjot_pkg::K_ERR) error_results++;
                    compare_field("out_kind", 32'(want.out_kind),
                                  32'(o_out_data.out_kind));
                    compare_field("out_byte", 32'(want.out_byte),
                                  32'(o_out_data.out_byte));
                    compare_field("error_code", 32'(want.error_code),
                                  32'(o_out_data.error_code));
                    compare_field("byte_pos", 32'(want.byte_pos),
                                  32'(o_out_data.byte_pos));
                    compare_field("pairs_seen", 32'(want.pairs_seen),
                                  32'(o_out_data.pairs_seen));
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (!hold_done && results_checked >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= idle_now();
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("flat_json_object_tokenizer_unit: mismatch");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_item(input logic [7:0] b, input bit restart);
        fjot_pkg::t_in item;
        while (pending_bytes.size() >= 256) @(negedge i_clk);
        item.in_byte   = b;
        item.start_msg = restart;
        pending_bytes.push_back(item);
    endtask

    task automatic flush_msg();
        foreach (msg_buf[i]) push_item(msg_buf[i], i == 0);
        msg_buf.delete();
        messages_sent++;
    endtask

    function automatic void add_blanks();
        logic [7:0] b;
        if ($urandom_range(1) == 0) return;
        repeat ($urandom_range(1, 2)) begin
            b = 8'($urandom_range(8, 13));
            msg_buf.push_back(b == 8'd8 ? fjot_pkg::CH_SPACE : b);
        end
    endfunction

    // structural byte, occasionally replaced by noise in broken messages
    function automatic void add_mark(input logic [7:0] c, input bit broken);
        if (broken && $urandom_range(99) < 6) msg_buf.push_back(8'($urandom_range(255)));
        else msg_buf.push_back(c);
    endfunction

    function automatic void add_text();
        logic [7:0] c;
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(255));
            if ($urandom_range(99) < 15) begin
                msg_buf.push_back(fjot_pkg::CH_BSLASH);
            end else if (c == fjot_pkg::CH_QUOTE || c == fjot_pkg::CH_BSLASH) begin
                c = c ^ 8'h01;
            end
            msg_buf.push_back(c);
        end
    endfunction

    task automatic queue_random_message(input bit broken);
        int pairs;
        int cut;
        pairs = $urandom_range(1, 4);
        add_blanks();
        add_mark(fjot_pkg::CH_LBRACE, broken);
        for (int p = 0; p < pairs; p++) begin
            add_blanks();
            add_mark(fjot_pkg::CH_QUOTE, broken);
            add_text();
            add_mark(fjot_pkg::CH_QUOTE, broken);
            add_blanks();
            add_mark(fjot_pkg::CH_COLON, broken);
            add_blanks();
            add_mark(fjot_pkg::CH_QUOTE, broken);
            add_text();
            add_mark(fjot_pkg::CH_QUOTE, broken);
            add_blanks();
            add_mark(p == pairs - 1 ? fjot_pkg::CH_RBRACE : fjot_pkg::CH_COMMA, broken);
        end
        if (broken && $urandom_range(3) == 0) begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut) void'(msg_buf.pop_back());
        end
        random_bytes += msg_buf.size();
        // bytes after the closing brace are ignored by the parser
        repeat ($urandom_range(0, 2)) msg_buf.push_back(8'($urandom_range(255)));
        flush_msg();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // stimulus
    initial begin
        // escaped quote and backslash, zero byte, tab in value, trailing byte
        msg_buf = '{fjot_pkg::CH_SPACE, fjot_pkg::CH_LBRACE, fjot_pkg::CH_QUOTE, 8'h00,
                    fjot_pkg::CH_BSLASH, fjot_pkg::CH_QUOTE, fjot_pkg::CH_QUOTE,
                    fjot_pkg::CH_COLON, fjot_pkg::CH_QUOTE, fjot_pkg::CH_TAB,
                    fjot_pkg::CH_BSLASH, fjot_pkg::CH_BSLASH, fjot_pkg::CH_QUOTE,
                    fjot_pkg::CH_RBRACE, 8'hFF};
        flush_msg();
        // missing opening brace, then held error
        msg_buf = '{8'h78, fjot_pkg::CH_LBRACE};
        flush_msg();
        // empty object is rejected at the closing brace
        msg_buf = '{fjot_pkg::CH_LBRACE, fjot_pkg::CH_RBRACE};
        flush_msg();
        // missing colon
        msg_buf = '{fjot_pkg::CH_LBRACE, fjot_pkg::CH_QUOTE, fjot_pkg::CH_QUOTE,
                    fjot_pkg::CH_COMMA};
        flush_msg();
        // bad separator after a value
        msg_buf = '{fjot_pkg::CH_LBRACE, fjot_pkg::CH_QUOTE, fjot_pkg::CH_QUOTE,
                    fjot_pkg::CH_COLON, fjot_pkg::CH_QUOTE, fjot_pkg::CH_QUOTE,
                    fjot_pkg::CH_COLON};
        flush_msg();

        // random messages: mostly well formed, some broken, some pure noise
        while (random_bytes < RANDOM_BYTES) begin
            if ($urandom_range(99) < 6) begin
                repeat ($urandom_range(1, 8)) msg_buf.push_back(8'($urandom_range(255)));
                random_bytes += msg_buf.size();
                flush_msg();
            end else begin
                queue_random_message($urandom_range(99) < 20);
            end
        end

        // drain
        while (pending_bytes.size() != 0 || i_in_valid) @(negedge i_clk);
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d messages, %0d bytes, %0d results checked (%0d object ends, %0d errors)",
                 messages_sent, bytes_sent, results_checked, objects_closed, error_results);
        $display("random idling on both sides and one receiver hold-off of %0d cycles",
                 HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("flat_json_object_tokenizer_unit: match");
        end else begin
            $display("flat_json_object_tokenizer_unit: mismatch");
        end
        $finish;
    end

endmodule
